@@ hdl/differential_drive_odometry_core_macros.svh @@
// assertion macros used by the checker file
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH

// checked only outside reset
`define DDO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked at every edge, reset included
`define DDO_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ hdl/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, constants and tables for the differential drive odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_LEN   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // gain-compensated unit vector, Q4.30
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    // radians to 2^-32 turn, Q16
    localparam logic signed [32:0] TURN_PER_RAD_Q16 = 33'sd42722829;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        REG_RIGHT_SCALE = 2'd0,
        REG_LEFT_SCALE  = 2'd1,
        REG_INV_TRACK   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic [62:0]        stamp_us;
    } in_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [31:0] heading;
        logic [62:0]        stamp_out;
    } out_t;

    // vector handed from cell to cell
    typedef struct packed {
        logic               vld;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cd_t;

endpackage

@@ hdl/ddo_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// ddo_cordic_cell
// One registered rotation-mode CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module ddo_cordic_cell
    import ddo_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cd_t         cd_in,
    input  logic [4:0]  shamt,
    input  logic [31:0] atan,
    output cd_t         cd_out
);

    cd_t               cd_reg;
    cd_t               cd_next;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] da;

    always_comb begin
        dx = cd_in.y >>> shamt;
        dy = cd_in.x >>> shamt;
        da = $signed({2'b00, atan});
        cd_next.vld = cd_in.vld;
        if (!cd_in.z[33]) begin
            cd_next.x = cd_in.x - dx;
            cd_next.y = cd_in.y + dy;
            cd_next.z = cd_in.z - da;
        end else begin
            cd_next.x = cd_in.x + dx;
            cd_next.y = cd_in.y - dy;
            cd_next.z = cd_in.z + da;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cd_reg.vld <= 1'b0;
        end else begin
            cd_reg.vld <= cd_next.vld;
        end
        cd_reg.x <= cd_next.x;
        cd_reg.y <= cd_next.y;
        cd_reg.z <= cd_next.z;
    end

    assign cd_out = cd_reg;

endmodule

@@ hdl/ddo_cordic_chain.sv @@
// ----------------------------------------------------------------------------
// ddo_cordic_chain
// Row of CORDIC cells, one micro-rotation per cell, each cell registering the
// vector on its way to the next.
// ----------------------------------------------------------------------------
module ddo_cordic_chain
    import ddo_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cd_t  cd_in,
    output cd_t  cd_out
);

    cd_t stage [CORDIC_LEN+1];

    assign stage[0] = cd_in;

    for (genvar i = 0; i < CORDIC_LEN; i++) begin : g_cell
        ddo_cordic_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cd_in   (stage[i]),
            .shamt   (5'(i)),
            .atan    (ATAN_TURNS[i]),
            .cd_out  (stage[i+1])
        );
    end

    assign cd_out = stage[CORDIC_LEN];

endmodule

@@ hdl/differential_drive_odometry_core.sv @@
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Wheel odometry: heading, step distance and saturating X/Y pose per sample.
// ----------------------------------------------------------------------------
// One sample is processed at a time. From acceptance to result it passes
// through the shared 33x33 multiplier for the wheel products, heading and
// phase, through the cells of the CORDIC row, again through the multiplier
// for the X and Y increments, and then into the output register. The input
// is ready again in the cycle after the result is loaded, so no new sample
// is taken before the last one is finished. A finished pose waits in the
// output register while the next sample is accepted; the next result is held
// back until it is taken.
module differential_drive_odometry_core
    import ddo_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CALC = 5'b00010,
        ST_WAIT = 5'b00100,
        ST_ADV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] right_scale_reg, left_scale_reg, inv_track_reg;
    logic        started_reg;
    logic [31:0] origin_l_reg, origin_r_reg, last_l_reg, last_r_reg;
    logic [31:0] cur_l_reg, cur_r_reg;
    logic [62:0] stamp_reg;
    logic signed [47:0] acc_x_reg, acc_y_reg;
    logic [3:0]  step_reg;
    logic signed [65:0] mul_p_reg;
    logic [63:0] pa_reg, pb_reg, pc_reg, pd_reg, lo_reg;
    logic [63:0] diff_reg, dist_reg;
    logic        hneg_reg, dneg_reg, flip_reg;
    logic signed [31:0] heading_reg;
    logic [31:0] c_mag_reg, s_mag_reg;
    logic        c_neg_reg, s_neg_reg;
    out_t        out_reg;
    logic        m_valid_reg;

    logic [31:0] dl0, dr0, dl1, dr1;
    logic signed [32:0] mul_a, mul_b;
    logic [63:0] mid;
    logic [64:0] diff_c, dist_c;
    logic [50:0] hm;
    logic signed [31:0] heading_sat;
    logic [47:0] ph48;
    logic [31:0] phase;
    logic        flip;
    cd_t         cd_start, cd_end;
    logic signed [33:0] c_val, s_val;
    logic        accept, out_free;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // sign and magnitude sum
    function automatic logic [64:0] combine(input logic [63:0] ma, input logic sa,
                                            input logic [63:0] mb, input logic sb);
        if (sa == sb) begin
            return {sa, ma + mb};
        end else if (ma >= mb) begin
            return {sa, ma - mb};
        end else begin
            return {sb, mb - ma};
        end
    endfunction

    function automatic logic signed [47:0] advance(input logic signed [47:0] acc,
                                                   input logic [63:0] m,
                                                   input logic neg);
        logic [53:0]        d;
        logic signed [54:0] dv;
        logic signed [54:0] sum;
        d   = {1'b0, m[63:11]} + 54'(m[10]);
        dv  = neg ? -$signed({1'b0, d}) : $signed({1'b0, d});
        sum = 55'(acc) + dv;
        if (sum > 55'sh0_7FFF_FFFF_FFFF) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (sum < -55'sh0_8000_0000_0000) begin
            return 48'sh8000_0000_0000;
        end else begin
            return sum[47:0];
        end
    endfunction

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign dl0 = cur_l_reg - origin_l_reg;
    assign dr0 = cur_r_reg - origin_r_reg;
    assign dl1 = cur_l_reg - last_l_reg;
    assign dr1 = cur_r_reg - last_r_reg;

    assign diff_c = combine(pa_reg, dr0[31], pb_reg, !dl0[31]);
    assign dist_c = combine(pc_reg, dl1[31], pd_reg, dr1[31]);

    // upper partial product plus carry-in of the lower one
    assign mid = mul_p_reg[63:0] + {32'd0, lo_reg[63:32]};

    assign hm = {1'b0, mid[63:14]} + 51'(mid[13]);
    always_comb begin
        if (hneg_reg) begin
            heading_sat = (hm > 51'h8000_0000) ? 32'sh8000_0000 : -$signed(hm[31:0]);
        end else begin
            heading_sat = (hm > 51'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(hm[31:0]);
        end
    end

    // phase in 2^-32 turn, second and third quadrants turned by half a turn
    assign ph48  = mul_p_reg[47:0] + 48'h8000;
    assign phase = ph48[47:16];
    assign flip  = phase[31] ^ phase[30];

    always_comb begin
        cd_start.vld = (state_reg == ST_CALC) && (step_reg == 4'd9);
        cd_start.x   = CORDIC_X0;
        cd_start.y   = '0;
        cd_start.z   = 34'($signed({phase[31] ^ flip, phase[30:0]}));
    end

    ddo_cordic_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cd_in   (cd_start),
        .cd_out  (cd_end)
    );

    assign c_val = flip_reg ? -cd_end.x : cd_end.x;
    assign s_val = flip_reg ? -cd_end.y : cd_end.y;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_CALC) begin
            case (step_reg)
                4'd0: begin
                    mul_a = {1'b0, abs32(dr0)};
                    mul_b = {1'b0, right_scale_reg};
                end
                4'd1: begin
                    mul_a = {1'b0, abs32(dl0)};
                    mul_b = {1'b0, left_scale_reg};
                end
                4'd2: begin
                    mul_a = {1'b0, abs32(dl1)};
                    mul_b = {1'b0, left_scale_reg};
                end
                4'd3: begin
                    mul_a = {1'b0, abs32(dr1)};
                    mul_b = {1'b0, right_scale_reg};
                end
                4'd5: begin
                    mul_a = {1'b0, diff_reg[31:0]};
                    mul_b = {1'b0, inv_track_reg};
                end
                4'd6: begin
                    mul_a = {1'b0, diff_reg[63:32]};
                    mul_b = {1'b0, inv_track_reg};
                end
                4'd8: begin
                    mul_a = 33'(heading_reg);
                    mul_b = TURN_PER_RAD_Q16;
                end
                default: ;
            endcase
        end else if (state_reg == ST_ADV) begin
            case (step_reg)
                4'd0: begin
                    mul_a = {1'b0, dist_reg[31:0]};
                    mul_b = {1'b0, c_mag_reg};
                end
                4'd1: begin
                    mul_a = {1'b0, dist_reg[63:32]};
                    mul_b = {1'b0, c_mag_reg};
                end
                4'd2: begin
                    mul_a = {1'b0, dist_reg[31:0]};
                    mul_b = {1'b0, s_mag_reg};
                end
                4'd3: begin
                    mul_a = {1'b0, dist_reg[63:32]};
                    mul_b = {1'b0, s_mag_reg};
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CALC;
            ST_CALC: if (step_reg == 4'd9) state_next = ST_WAIT;
            ST_WAIT: if (cd_end.vld) state_next = ST_ADV;
            ST_ADV:  if (step_reg == 4'd4) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            started_reg     <= 1'b0;
            origin_l_reg    <= '0;
            origin_r_reg    <= '0;
            last_l_reg      <= '0;
            last_r_reg      <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            m_valid_reg     <= 1'b0;
            right_scale_reg <= 32'd10848795;
            left_scale_reg  <= 32'd10540704;
            inv_track_reg   <= 32'd1502448280;
        end else begin
            state_reg <= state_next;
            step_reg  <= (state_next == state_reg) ? step_reg + 4'd1 : 4'd0;

            if (cfg_we) begin
                case (cfg_index)
                    REG_RIGHT_SCALE: right_scale_reg <= cfg_data;
                    REG_LEFT_SCALE:  left_scale_reg  <= cfg_data;
                    REG_INV_TRACK:   inv_track_reg   <= cfg_data;
                    default: ;
                endcase
            end

            if (accept && !started_reg) begin
                started_reg  <= 1'b1;
                origin_l_reg <= s_data.left_count;
                origin_r_reg <= s_data.right_count;
                last_l_reg   <= s_data.left_count;
                last_r_reg   <= s_data.right_count;
            end

            if (state_reg == ST_ADV && step_reg == 4'd2) begin
                acc_x_reg <= advance(acc_x_reg, mid, dneg_reg ^ c_neg_reg);
            end
            if (state_reg == ST_ADV && step_reg == 4'd4) begin
                acc_y_reg <= advance(acc_y_reg, mid, dneg_reg ^ s_neg_reg);
            end

            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                last_l_reg  <= cur_l_reg;
                last_r_reg  <= cur_r_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_a * mul_b;
        if (accept) begin
            cur_l_reg <= s_data.left_count;
            cur_r_reg <= s_data.right_count;
            stamp_reg <= s_data.stamp_us;
        end
        if (state_reg == ST_CALC) begin
            case (step_reg)
                4'd1: pa_reg <= mul_p_reg[63:0];
                4'd2: pb_reg <= mul_p_reg[63:0];
                4'd3: pc_reg <= mul_p_reg[63:0];
                4'd4: begin
                    pd_reg   <= mul_p_reg[63:0];
                    hneg_reg <= diff_c[64];
                    diff_reg <= diff_c[63:0];
                end
                4'd5: begin
                    dneg_reg <= dist_c[64];
                    dist_reg <= dist_c[63:0];
                end
                4'd6: lo_reg <= mul_p_reg[63:0];
                4'd7: heading_reg <= heading_sat;
                4'd9: flip_reg <= flip;
                default: ;
            endcase
        end
        if (state_reg == ST_WAIT && cd_end.vld) begin
            c_neg_reg <= c_val[33];
            s_neg_reg <= s_val[33];
            c_mag_reg <= c_val[33] ? 32'(-c_val) : c_val[31:0];
            s_mag_reg <= s_val[33] ? 32'(-s_val) : s_val[31:0];
        end
        if (state_reg == ST_ADV && (step_reg == 4'd1 || step_reg == 4'd3)) begin
            lo_reg <= mul_p_reg[63:0];
        end
        if (state_reg == ST_DONE && out_free) begin
            out_reg.pos_x     <= acc_x_reg;
            out_reg.pos_y     <= acc_y_reg;
            out_reg.heading   <= heading_reg;
            out_reg.stamp_out <= stamp_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ hdl/ddo_checker.sv @@
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks of the odometry core, bound to the top level.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_core_macros.svh"

module ddo_checker
    import ddo_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    `DDO_ASSERT_RST(a_rst_no_result, !aresetn |=> !m_valid, "result valid after reset")
    `DDO_ASSERT(a_busy_after_take, s_valid && s_ready |=> !s_ready, "second sample taken while busy")
    `DDO_ASSERT(a_hold_result, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped")

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (.*);
